// ===== rtl/swed_pkg.sv =====
// ----------------------------------------------------------------------------
// swed_pkg: shared definitions for the sync word escaped deframer
// Widths, phase and event codes, escape constants and the sync byte select.
// ----------------------------------------------------------------------------
package swed_pkg;

    // Number of sync bytes in the sync pattern
    localparam int SYNC_BYTES = 4;
    localparam int SYNC_CNT_W = (SYNC_BYTES > 1) ? $clog2(SYNC_BYTES) : 1;
    localparam int SYNC_EXT_W = (8 * SYNC_BYTES > 32) ? 8 * SYNC_BYTES : 32;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 1'd1;

    // Reset values of the registers
    localparam logic [31:0]       SYNC_WORD_RST      = 32'h0000_0000;
    localparam logic [BYTE_W-1:0] PAYLOAD_LENGTH_RST = 8'd38;

    // Escape handling
    localparam logic [BYTE_W-1:0] ESC_BYTE    = 8'hFF;
    localparam logic [BYTE_W-1:0] PARITY_MARK = 8'h00;

    // Phase codes
    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_ESC    = 2'd2;
    localparam logic [1:0] PH_PARITY = 2'd3;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] EV_MISMATCH = 2'd1;
    localparam logic [KIND_W-1:0] EV_PARITY   = 2'd2;
    localparam logic [KIND_W-1:0] EV_BADESC   = 2'd3;

    typedef logic [SYNC_CNT_W-1:0] sync_cnt_t;

    // Expected sync byte k; first byte sits in the top byte of the pattern,
    // bytes beyond the 32-bit register read as zero
    function automatic logic [BYTE_W-1:0] expected_sync(
        input logic [31:0] word,
        input sync_cnt_t   k
    );
        logic [SYNC_EXT_W-1:0] ext;
        int                    sel;
        ext = SYNC_EXT_W'(word);
        sel = SYNC_BYTES - 1 - int'(k);
        return ext[8*sel +: 8];
    endfunction

endpackage

// ===== rtl/swed_if.sv =====
// ----------------------------------------------------------------------------
// swed_if: channel interfaces of the deframer
// Byte input channel, event output channel and register write channel.
// ----------------------------------------------------------------------------

// Received byte channel
interface swed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Event channel
interface swed_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] data_byte;
    logic [7:0] byte_position;
    logic       frame_last;

    modport source (output valid, output event_kind, output data_byte,
                    output byte_position, output frame_last, input ready);
    modport sink   (input valid, input event_kind, input data_byte,
                    input byte_position, input frame_last, output ready);
endinterface

// Register write channel
interface swed_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sync_word_escaped_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// sync_word_escaped_deframer_unit: fixed-length sync word deframer
// Hunts for the sync pattern, collects a fixed number of escaped payload
// bytes and reports payload bytes and framing errors as events.
// ----------------------------------------------------------------------------

// One byte is accepted on every cycle that the event side keeps up; an
// accepted byte is held in the input register, where the deframer state is
// updated, and its event, if it has one, then moves to the event register.
// The event register holds a result while the next byte is taken in; when
// it stays stalled, the input register fills and rx.ready drops. Registers
// are written through cfg (always ready) and should only be changed while
// no byte is in flight.
module sync_word_escaped_deframer_unit (
    input  logic              clk,
    input  logic              rst_n,
    swed_in_if.sink           rx,
    swed_out_if.source        ev,
    swed_cfg_if.sink          cfg
);
    import swed_pkg::*;

    // Registers
    logic [31:0]         sync_word_reg;
    logic [BYTE_W-1:0]   payload_length_reg;

    // Input stage
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;

    // Deframer state
    logic [1:0]          phase_reg,         phase_next;
    sync_cnt_t           sync_matched_reg,  sync_matched_next;
    logic [BYTE_W-1:0]   payload_count_reg, payload_count_next;

    // Event register
    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_reg,   kind_next;
    logic [BYTE_W-1:0]   data_reg,   data_next;
    logic [BYTE_W-1:0]   pos_reg,    pos_next;
    logic                last_reg,   last_next;

    logic                has_result;
    logic                stage_fire;
    logic [BYTE_W-1:0]   count_inc;

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg      <= SYNC_WORD_RST;
            payload_length_reg <= PAYLOAD_LENGTH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SYNC_WORD:      sync_word_reg      <= cfg.data;
                REG_PAYLOAD_LENGTH: payload_length_reg <= cfg.data[BYTE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Decode of the byte in the input register
    assign count_inc = payload_count_reg + 8'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        sync_matched_next  = sync_matched_reg;
        payload_count_next = payload_count_reg;
        has_result         = 1'b0;
        kind_next          = EV_PAYLOAD;
        data_next          = in_byte_reg;
        pos_next           = '0;
        last_next          = 1'b0;

        case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte_reg == expected_sync(sync_word_reg, sync_matched_reg))
                begin
                    if (sync_matched_reg == SYNC_CNT_W'(SYNC_BYTES - 1))
                    begin
                        sync_matched_next  = '0;
                        payload_count_next = '0;
                        phase_next         = PH_DATA;
                    end
                    else
                    begin
                        sync_matched_next = sync_matched_reg + SYNC_CNT_W'(1);
                    end
                end
                else
                begin
                    sync_matched_next = '0;
                    has_result        = 1'b1;
                    kind_next         = EV_MISMATCH;
                end
            end
            PH_DATA, PH_ESC:
            begin
                if ((phase_reg == PH_DATA && in_byte_reg != ESC_BYTE) ||
                    (phase_reg == PH_ESC && in_byte_reg == ESC_BYTE))
                begin
                    // payload byte, plain or escaped
                    has_result = 1'b1;
                    kind_next  = EV_PAYLOAD;
                    pos_next   = payload_count_reg;
                    last_next  = (count_inc == payload_length_reg);
                    if (last_next)
                    begin
                        phase_next         = PH_HUNT;
                        sync_matched_next  = '0;
                        payload_count_next = '0;
                    end
                    else
                    begin
                        phase_next         = PH_DATA;
                        payload_count_next = count_inc;
                    end
                end
                else if (phase_reg == PH_DATA)
                begin
                    phase_next = PH_ESC;
                end
                else if (in_byte_reg == PARITY_MARK)
                begin
                    phase_next = PH_PARITY;
                end
                else
                begin
                    phase_next         = PH_HUNT;
                    sync_matched_next  = '0;
                    payload_count_next = '0;
                    has_result         = 1'b1;
                    kind_next          = EV_BADESC;
                end
            end
            default:
            begin
                // byte after a parity mark is reported and dropped
                phase_next         = PH_HUNT;
                sync_matched_next  = '0;
                payload_count_next = '0;
                has_result         = 1'b1;
                kind_next          = EV_PARITY;
            end
        endcase
    end

    // Input stage moves on when its event, if any, has room
    assign stage_fire = in_valid_reg && (!has_result || !out_valid_reg || ev.ready);
    assign rx.ready   = !in_valid_reg || stage_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // Deframer state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            sync_matched_reg  <= '0;
            payload_count_reg <= '0;
        end
        else if (stage_fire)
        begin
            phase_reg         <= phase_next;
            sync_matched_reg  <= sync_matched_next;
            payload_count_reg <= payload_count_next;
        end
    end

    // Event register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (ev.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && has_result)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            pos_reg  <= pos_next;
            last_reg <= last_next;
        end
    end

    assign ev.valid         = out_valid_reg;
    assign ev.event_kind    = kind_reg;
    assign ev.data_byte     = data_reg;
    assign ev.byte_position = pos_reg;
    assign ev.frame_last    = last_reg;

    // Checks
    a_err_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != EV_PAYLOAD) |-> (pos_reg == '0 && !last_reg))
        else $error("error event carries a position or last flag");

    a_match_only_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HUNT) |-> (sync_matched_reg == '0))
        else $error("sync match count left over outside hunt");

    a_count_clear_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (payload_count_reg == '0))
        else $error("payload count not cleared while hunting");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !stage_fire) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost");

endmodule
